FILE: design/motor_command_mapper_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef MOTOR_COMMAND_MAPPER_MACROS_SVH
`define MOTOR_COMMAND_MAPPER_MACROS_SVH

// Condition must hold at every active edge.
`define MCM_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mcm_pkg.sv
package mcm_pkg;

    typedef enum logic [1:0] {
        MT_BRUSHED   = 2'd0,
        MT_BRUSHLESS = 2'd1,
        MT_LOWSIDE   = 2'd2,
        MT_HBRIDGE   = 2'd3
    } motor_type_t;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_VELOCITY = 2'd1,
        OP_COAST    = 2'd2,
        OP_BRAKE    = 2'd3
    } op_t;

    typedef enum logic {
        CFG_MOTOR_TYPE    = 1'b0,
        CFG_STARTUP_DELAY = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t               operation;
        logic signed [7:0] amount;
    } cmd_t;

    typedef struct packed {
        logic [7:0] servo_angle;
        logic [7:0] pwm_a;
        logic [7:0] pwm_b;
        logic       armed;
    } res_t;

    typedef struct packed {
        logic [7:0] angle;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
    } held_t;

    localparam int unsigned DUTY_MAX = 255;

    localparam logic [7:0]  BRUSHED_NEUTRAL   = 8'd90;
    localparam logic [7:0]  BRUSHED_FWD_MAX   = 8'd160;
    localparam logic [7:0]  BRUSHED_BRAKE     = 8'd20;
    localparam logic [7:0]  BRUSHLESS_NEUTRAL = 8'd0;
    localparam logic [7:0]  BRUSHLESS_FWD_MAX = 8'd160;
    localparam logic [15:0] DELAY_RESET       = 16'd4000;
    localparam logic [6:0]  PCT_FULL          = 7'd100;

    // x / 100 == (x * 5243) >> 19, exact for x below 43690
    localparam int unsigned PCT_RECIP = 5243;
    localparam int unsigned PCT_SHIFT = 19;

    localparam int unsigned FWD_SPAN   = BRUSHED_FWD_MAX - BRUSHED_NEUTRAL;
    localparam int unsigned BRAKE_SPAN = BRUSHED_NEUTRAL - BRUSHED_BRAKE;
    localparam int unsigned BL_SPAN    = BRUSHLESS_FWD_MAX - BRUSHLESS_NEUTRAL;

    localparam logic [9:0]  DUTY_INT        = 10'(DUTY_MAX / 100);
    localparam logic [19:0] DUTY_FRAC_RCP   = 20'((DUTY_MAX % 100) * PCT_RECIP);
    localparam logic [9:0]  FWD_INT         = 10'(FWD_SPAN / 100);
    localparam logic [19:0] FWD_FRAC_RCP    = 20'((FWD_SPAN % 100) * PCT_RECIP);
    localparam logic [9:0]  BRAKE_INT       = 10'(BRAKE_SPAN / 100);
    localparam logic [19:0] BRAKE_FRAC_RCP  = 20'((BRAKE_SPAN % 100) * PCT_RECIP);
    localparam logic [9:0]  BL_INT          = 10'(BL_SPAN / 100);
    localparam logic [19:0] BL_FRAC_RCP     = 20'((BL_SPAN % 100) * PCT_RECIP);

    localparam logic [7:0]  DUTY_TOP = (DUTY_MAX > 255) ? 8'd255 : 8'(DUTY_MAX);

    // floor(mag * k / 100) with k split into whole hundreds and remainder
    function automatic logic [16:0] pct_scale(input logic [6:0]  mag,
                                              input logic [9:0]  int_part,
                                              input logic [19:0] frac_rcp);
        logic [16:0] whole;
        logic [26:0] frac_prod;
        whole     = 17'(mag) * 17'(int_part);
        frac_prod = 27'(mag) * 27'(frac_rcp);
        return whole + 17'(frac_prod >> PCT_SHIFT);
    endfunction

    function automatic logic [7:0] duty_of(input logic [6:0] mag);
        logic [16:0] d;
        d = pct_scale(mag, DUTY_INT, DUTY_FRAC_RCP);
        return (d > 17'd255) ? 8'd255 : d[7:0];
    endfunction

    function automatic logic [7:0] neutral_of(input motor_type_t t);
        return (t == MT_BRUSHLESS) ? BRUSHLESS_NEUTRAL : BRUSHED_NEUTRAL;
    endfunction

endpackage

FILE: design/mcm_map.sv
module mcm_map (
    input  mcm_pkg::motor_type_t motor_type,
    input  mcm_pkg::cmd_t        cmd,
    input  logic                 armed,
    input  mcm_pkg::held_t       held,
    output mcm_pkg::held_t       held_next
);

    logic signed [7:0] clamped;
    logic [6:0]        mag;
    logic              positive;
    logic              non_neg;
    logic [7:0]        fwd_angle;
    logic [7:0]        brake_angle;
    logic [7:0]        bl_angle;
    logic [7:0]        duty;
    logic [7:0]        inv_duty;

    always_comb
    begin
        priority if (cmd.amount > 8'sd100)
        begin
            clamped = 8'sd100;
        end
        else if (cmd.amount < -8'sd100)
        begin
            clamped = -8'sd100;
        end
        else
        begin
            clamped = cmd.amount;
        end
    end

    assign positive = (clamped > 8'sd0);
    assign non_neg  = ~clamped[7];
    assign mag      = clamped[7] ? 7'(-clamped) : clamped[6:0];

    assign fwd_angle   = mcm_pkg::BRUSHED_NEUTRAL
                       + 8'(mcm_pkg::pct_scale(mag, mcm_pkg::FWD_INT, mcm_pkg::FWD_FRAC_RCP));
    assign brake_angle = mcm_pkg::BRUSHED_NEUTRAL
                       - 8'(mcm_pkg::pct_scale(mag, mcm_pkg::BRAKE_INT,
                                               mcm_pkg::BRAKE_FRAC_RCP));
    assign bl_angle    = mcm_pkg::BRUSHLESS_NEUTRAL
                       + 8'(mcm_pkg::pct_scale(mag, mcm_pkg::BL_INT, mcm_pkg::BL_FRAC_RCP));
    assign duty        = mcm_pkg::duty_of(mag);
    assign inv_duty    = (mcm_pkg::DUTY_TOP > duty) ? (mcm_pkg::DUTY_TOP - duty) : 8'd0;

    always_comb
    begin
        held_next = held;
        unique case (motor_type)
            mcm_pkg::MT_BRUSHED:
            begin
                if (armed)
                begin
                    unique case (cmd.operation)
                        mcm_pkg::OP_VELOCITY:
                            held_next.angle = positive ? fwd_angle : mcm_pkg::BRUSHED_NEUTRAL;
                        mcm_pkg::OP_BRAKE:
                            held_next.angle = positive ? brake_angle : mcm_pkg::BRUSHED_NEUTRAL;
                        mcm_pkg::OP_COAST,
                        mcm_pkg::OP_TICK:
                            held_next.angle = mcm_pkg::BRUSHED_NEUTRAL;
                    endcase
                end
            end
            mcm_pkg::MT_BRUSHLESS:
            begin
                if (armed)
                begin
                    held_next.angle = (cmd.operation == mcm_pkg::OP_VELOCITY && positive)
                                    ? bl_angle : mcm_pkg::BRUSHLESS_NEUTRAL;
                end
            end
            mcm_pkg::MT_LOWSIDE:
            begin
                held_next.duty_a = (cmd.operation == mcm_pkg::OP_VELOCITY && non_neg)
                                 ? duty : 8'd0;
            end
            mcm_pkg::MT_HBRIDGE:
            begin
                unique case (cmd.operation)
                    mcm_pkg::OP_VELOCITY:
                    begin
                        held_next.duty_a = non_neg ? inv_duty : mcm_pkg::DUTY_TOP;
                        held_next.duty_b = non_neg ? mcm_pkg::DUTY_TOP : inv_duty;
                    end
                    mcm_pkg::OP_COAST:
                    begin
                        held_next.duty_a = 8'd0;
                        held_next.duty_b = 8'd0;
                    end
                    mcm_pkg::OP_BRAKE,
                    mcm_pkg::OP_TICK:
                    begin
                        held_next.duty_a = duty;
                        held_next.duty_b = duty;
                    end
                endcase
            end
        endcase
    end

endmodule

FILE: design/motor_command_mapper.sv
// A command's transaction loads the input register; once the result side can take it,
// the mapped result is registered in the result register and res_valid rises.
// Throughput: one transaction per cycle while res_stall does not hold back a result;
// the input register hands each item to the mapping logic and result register as it takes the next.
// Ticks use one slot and produce no result.
// Reset (rst_n low, async): type brushed, delay 4000 ms, elapsed 0,
// angle 90, duties 0, both pipeline registers empty.
`include "motor_command_mapper_macros.svh"

module motor_command_mapper (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mcm_pkg::cmd_t  cmd_data,
    output logic           res_valid,
    input  logic           res_stall,
    output mcm_pkg::res_t  res_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);

    mcm_pkg::motor_type_t type_reg, type_next;
    logic [15:0]          delay_reg, delay_next;
    logic [16:0]          elapsed_reg, elapsed_next;
    mcm_pkg::held_t       held_reg, held_next, mapped;

    logic                 cmd_vld_reg, cmd_vld_next;
    mcm_pkg::cmd_t        cmd_reg;
    logic                 res_vld_reg, res_vld_next;
    mcm_pkg::res_t        res_reg;

    logic                 armed;
    logic                 is_tick;
    logic                 advance;
    logic                 cmd_take;
    mcm_pkg::cfg_idx_t    cfg_sel;

    assign armed    = (elapsed_reg > {1'b0, delay_reg});
    assign is_tick  = (cmd_reg.operation == mcm_pkg::OP_TICK);
    assign advance  = cmd_vld_reg & (is_tick | ~res_vld_reg | ~res_stall);
    assign cmd_stall = cmd_vld_reg & ~advance;
    assign cmd_take = cmd_valid & ~cmd_stall;
    assign cfg_sel  = mcm_pkg::cfg_idx_t'(cfg_index);

    mcm_map u_map (
        .motor_type (type_reg),
        .cmd        (cmd_reg),
        .armed      (armed),
        .held       (held_reg),
        .held_next  (mapped)
    );

    always_comb
    begin
        type_next    = type_reg;
        delay_next   = delay_reg;
        elapsed_next = elapsed_reg;
        held_next    = held_reg;
        if (cfg_we)
        begin
            unique case (cfg_sel)
                mcm_pkg::CFG_MOTOR_TYPE:
                begin
                    type_next        = mcm_pkg::motor_type_t'(cfg_data[1:0]);
                    elapsed_next     = 17'd0;
                    held_next.angle  = mcm_pkg::neutral_of(type_next);
                    held_next.duty_a = 8'd0;
                    held_next.duty_b = 8'd0;
                end
                mcm_pkg::CFG_STARTUP_DELAY:
                begin
                    delay_next = cfg_data;
                end
            endcase
        end
        else if (advance)
        begin
            if (is_tick)
            begin
                if (!armed)
                begin
                    elapsed_next = elapsed_reg + 17'd1;
                end
            end
            else
            begin
                held_next = mapped;
            end
        end
    end

    always_comb
    begin
        cmd_vld_next = cmd_vld_reg;
        if (cmd_take)
        begin
            cmd_vld_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_vld_next = 1'b0;
        end

        res_vld_next = res_vld_reg;
        if (advance && !is_tick)
        begin
            res_vld_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg        <= mcm_pkg::MT_BRUSHED;
            delay_reg       <= mcm_pkg::DELAY_RESET;
            elapsed_reg     <= 17'd0;
            held_reg.angle  <= mcm_pkg::neutral_of(mcm_pkg::MT_BRUSHED);
            held_reg.duty_a <= 8'd0;
            held_reg.duty_b <= 8'd0;
            cmd_vld_reg     <= 1'b0;
            res_vld_reg     <= 1'b0;
        end
        else
        begin
            type_reg    <= type_next;
            delay_reg   <= delay_next;
            elapsed_reg <= elapsed_next;
            held_reg    <= held_next;
            cmd_vld_reg <= cmd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd_data;
        end
        if (advance && !is_tick)
        begin
            res_reg.servo_angle <= mapped.angle;
            res_reg.pwm_a       <= mapped.duty_a;
            res_reg.pwm_b       <= mapped.duty_b;
            res_reg.armed       <= armed;
        end
    end

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    `MCM_ASSERT(a_duty_b_hbridge_only,
                (held_reg.duty_b == 8'd0) || (type_reg == mcm_pkg::MT_HBRIDGE),
                "second duty set on a non H-bridge type")
    `MCM_ASSERT(a_servo_no_duty,
                !((type_reg == mcm_pkg::MT_BRUSHED || type_reg == mcm_pkg::MT_BRUSHLESS)
                  && held_reg.duty_a != 8'd0),
                "servo type holds a nonzero duty")
    `MCM_ASSERT(a_angle_range,
                held_reg.angle <= mcm_pkg::BRUSHED_FWD_MAX,
                "held servo angle out of range")
    `MCM_ASSERT_NEXT(a_cmd_held_on_stall,
                     cmd_vld_reg && !is_tick && res_vld_reg && res_stall,
                     cmd_vld_reg,
                     "pending command dropped while result stalled")

endmodule
